// ----- hdl/tvsd_pkg.sv -----
// ----------------------------------------------------------------------------
// tvsd_pkg
// Shared types and constants for the tagged value stream decoder: header
// byte boundaries, token kind codes, parse phases and the queue entry.
// ----------------------------------------------------------------------------
package tvsd_pkg;

  // Default depth of the queue between front and back (at least 2)
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Header byte class boundaries
  localparam logic [7:0] HDR_NEG_INT_LO = 8'd64;
  localparam logic [7:0] HDR_DBL_LO     = 8'd125;
  localparam logic [7:0] HDR_DBL_ZERO   = 8'd126;
  localparam logic [7:0] HDR_RAW_LO     = 8'd128;
  localparam logic [7:0] HDR_RAWLEN_LO  = 8'd228;
  localparam logic [7:0] HDR_INTLEN_LO  = 8'd232;
  localparam logic [7:0] HDR_DBL8       = 8'd236;
  localparam logic [7:0] NEG_INT_BASE   = 8'd63;

  // Fixed double bit patterns
  localparam logic [63:0] DBL_MINUS_ONE = 64'hBFF0_0000_0000_0000;
  localparam logic [63:0] DBL_ZERO      = 64'h0000_0000_0000_0000;
  localparam logic [63:0] DBL_PLUS_ONE  = 64'h3FF0_0000_0000_0000;

  // Token kind codes
  localparam logic [2:0] KIND_INT   = 3'd0;
  localparam logic [2:0] KIND_DBL   = 3'd1;
  localparam logic [2:0] KIND_RAWH  = 3'd2;
  localparam logic [2:0] KIND_BYTE  = 3'd3;
  localparam logic [2:0] KIND_MARK  = 3'd4;
  localparam logic [2:0] KIND_TRUNC = 3'd5;

  // Class of a byte read as a header
  typedef enum logic [2:0] {
    HC_IMM_INT = 3'd0,  // small integer, value ready
    HC_IMM_DBL = 3'd1,  // fixed double, value ready
    HC_RAW     = 3'd2,  // short raw string, length ready
    HC_RAWLEN  = 3'd3,  // raw string with explicit length bytes
    HC_INTLEN  = 3'd4,  // integer with explicit value bytes
    HC_DBL8    = 3'd5,  // 8-byte double
    HC_MARK    = 3'd6   // structure or special marker
  } hdr_class_t;

  // Parse phase of the back end
  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_RAWLEN  = 5'b00010,
    PH_INT     = 5'b00100,
    PH_DBL     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  // One classified byte as it travels through the queue
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    hdr_class_t  hdr_class;
    logic [1:0]  len_sel;    // log2 of the explicit byte count
    logic [63:0] imm_value;  // value of a header that completes at once
  } entry_t;

endpackage

// ----- hdl/tvsd_front.sv -----
// ----------------------------------------------------------------------------
// tvsd_front
// Input stage: accept a byte, classify it as a header and hand the entry to
// the queue.
// ----------------------------------------------------------------------------
module tvsd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  input  logic            q_full,
  output logic            q_push,
  output tvsd_pkg::entry_t q_entry
);

  logic             fr_valid;
  tvsd_pkg::entry_t fr_entry;
  tvsd_pkg::entry_t cls;
  logic [7:0]       neg_val;
  logic [7:0]       raw_len;

  assign in_stall = fr_valid && q_full;
  assign q_push   = fr_valid && !q_full;
  assign q_entry  = fr_entry;

  assign neg_val = tvsd_pkg::NEG_INT_BASE - data_byte;
  assign raw_len = data_byte - tvsd_pkg::HDR_RAW_LO;

  always_comb begin
    cls.data_byte = data_byte;
    cls.last_byte = last_byte;
    cls.len_sel   = data_byte[1:0];
    cls.imm_value = {56'd0, data_byte};
    if (data_byte < tvsd_pkg::HDR_NEG_INT_LO) begin
      cls.hdr_class = tvsd_pkg::HC_IMM_INT;
    end else if (data_byte < tvsd_pkg::HDR_DBL_LO) begin
      cls.hdr_class = tvsd_pkg::HC_IMM_INT;
      cls.imm_value = {{56{neg_val[7]}}, neg_val};
    end else if (data_byte < tvsd_pkg::HDR_RAW_LO) begin
      cls.hdr_class = tvsd_pkg::HC_IMM_DBL;
      if (data_byte == tvsd_pkg::HDR_DBL_LO) begin
        cls.imm_value = tvsd_pkg::DBL_MINUS_ONE;
      end else if (data_byte == tvsd_pkg::HDR_DBL_ZERO) begin
        cls.imm_value = tvsd_pkg::DBL_ZERO;
      end else begin
        cls.imm_value = tvsd_pkg::DBL_PLUS_ONE;
      end
    end else if (data_byte < tvsd_pkg::HDR_RAWLEN_LO) begin
      cls.hdr_class = tvsd_pkg::HC_RAW;
      cls.imm_value = {56'd0, raw_len};
    end else if (data_byte < tvsd_pkg::HDR_INTLEN_LO) begin
      cls.hdr_class = tvsd_pkg::HC_RAWLEN;
    end else if (data_byte < tvsd_pkg::HDR_DBL8) begin
      cls.hdr_class = tvsd_pkg::HC_INTLEN;
    end else if (data_byte == tvsd_pkg::HDR_DBL8) begin
      cls.hdr_class = tvsd_pkg::HC_DBL8;
      cls.len_sel   = 2'd3;
    end else begin
      cls.hdr_class = tvsd_pkg::HC_MARK;
    end
  end

  // Hold the stage while the queue is full
  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (!in_stall) begin
      fr_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      fr_entry <= cls;
    end
  end

endmodule

// ----- hdl/tvsd_queue.sv -----
// ----------------------------------------------------------------------------
// tvsd_queue
// Small first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module tvsd_queue #(
  parameter int DEPTH = tvsd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tvsd_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output tvsd_pkg::entry_t head_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tvsd_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == FULL_CNT);
  assign not_empty  = (count != '0);
  assign do_pop     = pop && not_empty;
  assign head_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- hdl/tvsd_back.sv -----
// ----------------------------------------------------------------------------
// tvsd_back
// Parse engine: track the token phase, gather length and value bytes, count
// raw payload and drive the registered result.
// ----------------------------------------------------------------------------
module tvsd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_not_empty,
  input  tvsd_pkg::entry_t q_entry,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       token_kind,
  output logic [63:0]      token_value,
  output logic             stream_end
);

  tvsd_pkg::phase_t phase, phase_next;
  logic [3:0]  bytes_left, bytes_left_next, bl_dec;
  logic [2:0]  byte_index, byte_index_next;
  logic [63:0] gather_word, gather_word_next;
  logic [63:0] payload_left, payload_left_next, pl_dec;
  logic [63:0] gathered, extended;
  logic        sign_bit;
  logic        have;
  logic [2:0]  kind;
  logic [63:0] value;
  logic        advance;

  assign advance = !out_valid || !out_stall;
  assign q_pop   = q_not_empty && advance;

  assign bl_dec   = (bytes_left != 4'd0) ? bytes_left - 4'd1 : 4'd0;
  assign pl_dec   = payload_left - 64'd1;
  assign gathered = gather_word | ({56'd0, q_entry.data_byte} << {byte_index, 3'b000});
  assign sign_bit = gathered[{byte_index, 3'b111}];

  // Sign-extend above the last gathered byte
  always_comb begin
    extended = gathered;
    for (int k = 0; k < 8; k++) begin
      if (3'(k) > byte_index) begin
        extended[8*k +: 8] = {8{sign_bit}};
      end
    end
  end

  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    byte_index_next   = byte_index;
    gather_word_next  = gather_word;
    payload_left_next = payload_left;
    have              = 1'b0;
    kind              = tvsd_pkg::KIND_INT;
    value             = '0;

    unique case (phase) inside
      tvsd_pkg::PH_HEADER: begin
        unique case (q_entry.hdr_class) inside
          tvsd_pkg::HC_IMM_INT: begin
            have  = 1'b1;
            kind  = tvsd_pkg::KIND_INT;
            value = q_entry.imm_value;
          end
          tvsd_pkg::HC_IMM_DBL: begin
            have  = 1'b1;
            kind  = tvsd_pkg::KIND_DBL;
            value = q_entry.imm_value;
          end
          tvsd_pkg::HC_RAW: begin
            have  = 1'b1;
            kind  = tvsd_pkg::KIND_RAWH;
            value = q_entry.imm_value;
            if (q_entry.imm_value != '0) begin
              phase_next        = tvsd_pkg::PH_PAYLOAD;
              payload_left_next = q_entry.imm_value;
            end
          end
          tvsd_pkg::HC_RAWLEN, tvsd_pkg::HC_INTLEN, tvsd_pkg::HC_DBL8: begin
            if (q_entry.hdr_class == tvsd_pkg::HC_RAWLEN) begin
              phase_next = tvsd_pkg::PH_RAWLEN;
            end else if (q_entry.hdr_class == tvsd_pkg::HC_INTLEN) begin
              phase_next = tvsd_pkg::PH_INT;
            end else begin
              phase_next = tvsd_pkg::PH_DBL;
            end
            bytes_left_next  = 4'b0001 << q_entry.len_sel;
            byte_index_next  = '0;
            gather_word_next = '0;
          end
          default: begin
            have  = 1'b1;
            kind  = tvsd_pkg::KIND_MARK;
            value = q_entry.imm_value;
          end
        endcase
      end
      tvsd_pkg::PH_PAYLOAD: begin
        have              = 1'b1;
        kind              = tvsd_pkg::KIND_BYTE;
        value             = {56'd0, q_entry.data_byte};
        payload_left_next = pl_dec;
        if (pl_dec == '0) begin
          phase_next = tvsd_pkg::PH_HEADER;
        end
      end
      tvsd_pkg::PH_RAWLEN, tvsd_pkg::PH_INT, tvsd_pkg::PH_DBL: begin
        gather_word_next = gathered;
        byte_index_next  = byte_index + 3'd1;
        bytes_left_next  = bl_dec;
        if (bl_dec == 4'd0) begin
          have             = 1'b1;
          gather_word_next = '0;
          byte_index_next  = '0;
          phase_next       = tvsd_pkg::PH_HEADER;
          if (phase == tvsd_pkg::PH_RAWLEN) begin
            kind  = tvsd_pkg::KIND_RAWH;
            value = gathered;
            if (gathered != '0) begin
              phase_next        = tvsd_pkg::PH_PAYLOAD;
              payload_left_next = gathered;
            end
          end else if (phase == tvsd_pkg::PH_INT) begin
            kind  = tvsd_pkg::KIND_INT;
            value = extended;
          end else begin
            kind  = tvsd_pkg::KIND_DBL;
            value = gathered;
          end
        end
      end
      default: begin
        phase_next = tvsd_pkg::PH_HEADER;
      end
    endcase

    // End of buffer: report an unfinished token, then drop all state
    if (q_entry.last_byte) begin
      if (phase_next == tvsd_pkg::PH_PAYLOAD) begin
        have  = 1'b1;
        kind  = tvsd_pkg::KIND_TRUNC;
        value = payload_left_next;
      end else if (phase_next != tvsd_pkg::PH_HEADER) begin
        have  = 1'b1;
        kind  = tvsd_pkg::KIND_TRUNC;
        value = {60'd0, bytes_left_next};
      end
      phase_next        = tvsd_pkg::PH_HEADER;
      bytes_left_next   = '0;
      byte_index_next   = '0;
      gather_word_next  = '0;
      payload_left_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tvsd_pkg::PH_HEADER;
      bytes_left   <= '0;
      byte_index   <= '0;
      gather_word  <= '0;
      payload_left <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        phase        <= phase_next;
        bytes_left   <= bytes_left_next;
        byte_index   <= byte_index_next;
        gather_word  <= gather_word_next;
        payload_left <= payload_left_next;
      end
      if (advance) begin
        out_valid <= q_pop && have;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && have) begin
      token_kind  <= kind;
      token_value <= value;
      stream_end  <= q_entry.last_byte;
    end
  end

endmodule

// ----- hdl/tagged_value_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// tagged_value_stream_decoder
// Streaming decoder for a tagged binary value format: one serialized byte in,
// at most one decoded token out.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+------------------------------
//   in      | input     | in_valid/in_stall  | data_byte, last_byte
//   out     | output    | out_valid/out_stall| token_kind, token_value,
//           |           |                    | stream_end
//
// One byte per clock cycle is sustained while out_stall is low; the queue
// drains at the rate of the back end's single phase update per cycle.
// A token becomes valid once its byte has passed the front register, the queue
// write and the back end's output register; an out stall can delay it.
// Reset (rst, synchronous) empties the front stage, the queue and the output
// register and returns the parser to the header phase.
// A stall on out holds the result; the queue of QUEUE_DEPTH entries absorbs
// bytes until it fills, and only then is in_stall raised.
//
// Structure: the front registers each byte and classifies it as a header
// (class, length selector and the value of headers that complete at once).
// The back owns the parse phase, the little-endian gather word, the byte
// counters and the raw payload counter, and decides what each byte means.
// ----------------------------------------------------------------------------
module tagged_value_stream_decoder #(
  parameter int QUEUE_DEPTH = tvsd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  token_kind,
  output logic [63:0] token_value,
  output logic        stream_end
);

  tvsd_pkg::entry_t push_entry;
  tvsd_pkg::entry_t head_entry;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_not_empty;

  // Accept and classify
  tvsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  // Decouple the two sides
  tvsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head_entry (head_entry)
  );

  // Parse and emit tokens
  tvsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_entry     (head_entry),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_kind  (token_kind),
    .token_value (token_value),
    .stream_end  (stream_end)
  );

endmodule

// ----- hdl/tvsd_checker.sv -----
// ----------------------------------------------------------------------------
// tvsd_checker
// Port-level checks for the tagged value stream decoder, bound to the top.
// ----------------------------------------------------------------------------
module tvsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  data_byte,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  token_kind,
  input logic [63:0] token_value,
  input logic        stream_end
);

  // Hold a stalled transaction
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable(token_kind) && $stable(token_value) && $stable(stream_end))
    else $error("stalled token dropped or changed");

  // A stalled input transaction stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(last_byte))
    else $error("stalled input byte dropped or changed");

  // Truncation is reported only at the end of a buffer
  a_trunc_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == tvsd_pkg::KIND_TRUNC) |-> stream_end)
    else $error("truncated token without stream end");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (token_kind == tvsd_pkg::KIND_INT) || (token_kind == tvsd_pkg::KIND_DBL) ||
      (token_kind == tvsd_pkg::KIND_RAWH) || (token_kind == tvsd_pkg::KIND_BYTE) ||
      (token_kind == tvsd_pkg::KIND_MARK) || (token_kind == tvsd_pkg::KIND_TRUNC))
    else $error("illegal token kind");

  // Reset leaves no result and no back pressure
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("state not cleared by reset");

endmodule

bind tagged_value_stream_decoder tvsd_checker u_tvsd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .data_byte   (data_byte),
  .last_byte   (last_byte),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .token_kind  (token_kind),
  .token_value (token_value),
  .stream_end  (stream_end)
);
